[hw/rtl/nls_pkg.sv]
// types, codes and constants shared by the numeric literal scanner
// no dependencies
package nls_pkg;

   localparam int MAX_LENGTH = 255;
   localparam logic [7:0] LEN_LIMIT = (MAX_LENGTH > 255) ? 8'd255 : 8'(MAX_LENGTH);

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_SIGN = 3'd1;
   localparam logic [2:0] M_ZERO = 3'd2;
   localparam logic [2:0] M_HEX  = 3'd3;
   localparam logic [2:0] M_OCT  = 3'd4;
   localparam logic [2:0] M_DEC  = 3'd5;
   localparam logic [2:0] M_FLT  = 3'd6;

   localparam logic [2:0] K_DEC = 3'd0;
   localparam logic [2:0] K_OCT = 3'd1;
   localparam logic [2:0] K_HEX = 3'd2;
   localparam logic [2:0] K_FLT = 3'd3;
   localparam logic [2:0] K_ERR = 3'd4;

   typedef struct packed {
      logic is_zero;
      logic is_nzdig;
      logic is_dig;
      logic is_oct;
      logic is_hex;
      logic is_x;
      logic is_dot;
      logic is_sign;
   } nls_class_type;

   typedef struct packed {
      logic       emit;
      logic [2:0] kind;
      logic [7:0] length;
      logic       has_sign;
      logic       too_long;
   } nls_result_type;

endpackage

[hw/rtl/numeric_literal_scanner_core.sv]
// numeric literal scanner top level: input register, scan step, result register
// a result passes from the input register through the scan step into the result register, which drives rsp
// throughput: one character per cycle while rsp is not stalled, set by the scan step
// a stalled result holds the scan step; the input register takes at most one more transfer, then holds
// reset: synchronous, clears both pipe valids and the scan state to idle
module numeric_literal_scanner_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] length, [8] has_sign, [9] too_long, zero above
   output logic [2:0]  rsp_tuser    // [2:0] kind
);
   import nls_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_ch_ff;
   logic           in_first_ff;
   logic           out_valid_ff, out_valid_in;
   nls_result_type res;
   nls_result_type out_res_ff;
   logic           advance;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff    <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   nls_step u_step (
      .clock (clock),
      .reset (reset),
      .step  (in_valid_ff && advance),
      .ch    (in_ch_ff),
      .first (in_first_ff),
      .res   (res)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (res.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.emit) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_res_ff.too_long, out_res_ff.has_sign, out_res_ff.length};
   assign rsp_tuser  = out_res_ff.kind;

endmodule

[hw/rtl/nls_char_class.sv]
// character classifier: sorts one byte into the classes the scanner tests
// depends on nls_pkg
module nls_char_class (
   input  logic [7:0]            ch,
   output nls_pkg::nls_class_type cls
);
   import nls_pkg::*;

   always_comb begin
      cls.is_zero  = (ch == 8'h30);
      cls.is_nzdig = ch inside {[8'h31:8'h39]};
      cls.is_dig   = ch inside {[8'h30:8'h39]};
      cls.is_oct   = ch inside {[8'h30:8'h37]};
      cls.is_hex   = ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
      cls.is_x     = (ch == 8'h78) || (ch == 8'h58);
      cls.is_dot   = (ch == 8'h2e);
      cls.is_sign  = (ch == 8'h2b) || (ch == 8'h2d);
   end

endmodule

[hw/rtl/nls_step.sv]
// scan state registers and the per-character transition and result logic
// depends on nls_pkg and nls_char_class
module nls_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             ch,
   input  logic                   first,
   output nls_pkg::nls_result_type res
);
   import nls_pkg::*;

   nls_class_type cls;
   logic [2:0]    mode_ff, mode_in;
   logic [7:0]    count_ff, count_in;
   logic          sign_ff, sign_in;
   logic [7:0]    base_count;
   logic          base_sign;
   logic [2:0]    cur_mode;
   logic          take;
   logic          done;
   logic [2:0]    take_mode;
   logic [2:0]    done_kind;

   nls_char_class u_class (
      .ch  (ch),
      .cls (cls)
   );

   always_comb begin
      base_count = first ? 8'd0 : count_ff;
      base_sign  = first ? 1'b0 : sign_ff;
      cur_mode   = first ? M_IDLE : mode_ff;
      take       = 1'b0;
      done       = 1'b0;
      take_mode  = M_IDLE;
      done_kind  = K_ERR;
      if (first) begin
         if (cls.is_zero) begin
            take = 1'b1; take_mode = M_ZERO;
         end else if (cls.is_nzdig) begin
            take = 1'b1; take_mode = M_DEC;
         end else if (cls.is_sign) begin
            take = 1'b1; take_mode = M_SIGN;
         end else begin
            done = 1'b1; done_kind = K_ERR;
         end
      end else begin
         case (cur_mode)
            M_SIGN: begin
               if (cls.is_zero) begin
                  take = 1'b1; take_mode = M_ZERO;
               end else if (cls.is_nzdig) begin
                  take = 1'b1; take_mode = M_DEC;
               end else begin
                  done = 1'b1; done_kind = K_ERR;
               end
            end
            M_ZERO: begin
               if (cls.is_x) begin
                  take = 1'b1; take_mode = M_HEX;
               end else if (cls.is_dot) begin
                  take = 1'b1; take_mode = M_FLT;
               end else if (cls.is_oct) begin
                  take = 1'b1; take_mode = M_OCT;
               end else begin
                  done = 1'b1; done_kind = K_OCT;
               end
            end
            M_HEX: begin
               if (cls.is_hex) begin
                  take = 1'b1; take_mode = M_HEX;
               end else begin
                  done = 1'b1; done_kind = K_HEX;
               end
            end
            M_OCT: begin
               if (cls.is_oct) begin
                  take = 1'b1; take_mode = M_OCT;
               end else begin
                  done = 1'b1; done_kind = K_OCT;
               end
            end
            M_DEC: begin
               if (cls.is_dig) begin
                  take = 1'b1; take_mode = M_DEC;
               end else if (cls.is_dot) begin
                  take = 1'b1; take_mode = M_FLT;
               end else begin
                  done = 1'b1; done_kind = K_DEC;
               end
            end
            M_FLT: begin
               if (cls.is_dig) begin
                  take = 1'b1; take_mode = M_FLT;
               end else begin
                  done = 1'b1; done_kind = K_FLT;
               end
            end
            default: begin
               take = 1'b0;
               done = 1'b0;
            end
         endcase
      end

      mode_in  = M_IDLE;
      count_in = base_count;
      sign_in  = base_sign;
      if (take) begin
         mode_in  = take_mode;
         count_in = (base_count < LEN_LIMIT) ? base_count + 8'd1 : base_count;
         if (first && cls.is_sign) begin
            sign_in = 1'b1;
         end
      end else if (done) begin
         count_in = 8'd0;
         sign_in  = 1'b0;
      end

      res.emit     = step && done;
      res.kind     = done_kind;
      res.length   = base_count;
      res.has_sign = base_sign;
      res.too_long = (base_count >= LEN_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         count_ff <= 8'd0;
         sign_ff  <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         sign_ff  <= sign_in;
      end
   end

endmodule

[hw/rtl/nls_checker.sv]
// port-level checks on the numeric literal scanner, bound to its top level
// depends on nls_pkg and numeric_literal_scanner_core
module nls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import nls_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= K_ERR)
      else $error("kind out of range");

   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9] == (rsp_tdata[7:0] == LEN_LIMIT)))
      else $error("too_long disagrees with length");

   a_err_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_ERR |-> rsp_tdata[7:0] == {7'd0, rsp_tdata[8]})
      else $error("error length must count only the sign");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

endmodule

bind numeric_literal_scanner_core nls_checker u_nls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
